// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active-low reset).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pnff_pkg.sv =====
// Types and constants for the packed nibble framebuffer fill unit.
`timescale 1ns / 1ps

package pnff_pkg;

    localparam int COORD_W  = 9;
    localparam int EXT_W    = COORD_W + 1;
    localparam int NIBBLE_W = 4;
    localparam int BYTE_W   = 2 * NIBBLE_W;
    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_HBAND = 2'd2,
        OP_VBAND = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [COORD_W-1:0]  x_left;
        logic [COORD_W-1:0]  x_right;
        logic [COORD_W-1:0]  y_top;
        logic [COORD_W-1:0]  y_bottom;
        logic [COORD_W-1:0]  thickness;
        logic [NIBBLE_W-1:0] color;
    } t_in_word;

    typedef struct packed {
        logic [NIBBLE_W-1:0] read_color;
        logic                status;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_WALK,
        ST_DRAIN,
        ST_RESP
    } t_state;

    // One pixel access handed from the walker to the read-modify-write stage.
    typedef struct packed {
        logic                valid;
        logic                rd;
        logic                hi;
        logic [NIBBLE_W-1:0] color;
    } t_pix_ctl;

endpackage

// ===== hw/rtl/pnff_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module pnff_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pnff_ctrl.sv =====
// Operation sequencer: clipping, row base and pixel walk over the band.
`timescale 1ns / 1ps

module pnff_ctrl import pnff_pkg::*; #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int ADDR_W        = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_word          i_data,
    output logic [ADDR_W-1:0] o_raddr,
    output t_pix_ctl          o_pix,
    output logic              o_start,
    output logic              o_res_valid,
    output logic              o_res_status,
    input  logic              i_res_ready
);

    localparam int ROW_BYTES = (SCREEN_WIDTH + 1) / 2;
    localparam logic [ADDR_W-1:0]  ROW_STEP = ADDR_W'(ROW_BYTES);
    localparam logic [EXT_W-1:0]   X_LIM    = EXT_W'(SCREEN_WIDTH);
    localparam logic [EXT_W-1:0]   Y_LIM    = EXT_W'(SCREEN_HEIGHT);
    localparam logic [COORD_W-1:0] X_LAST   = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_LAST   = COORD_W'(SCREEN_HEIGHT - 1);

    t_state              r_state, n_state;
    logic [COORD_W-1:0]  r_x, n_x;
    logic [COORD_W-1:0]  r_y, n_y;
    logic [COORD_W-1:0]  r_x0, n_x0;
    logic [COORD_W-1:0]  r_xe, n_xe;
    logic [COORD_W-1:0]  r_ye, n_ye;
    logic [ADDR_W-1:0]   r_row_base, n_row_base;
    logic [NIBBLE_W-1:0] r_color, n_color;
    logic                r_rd, n_rd;
    logic                r_flag, n_flag;

    logic [EXT_W-1:0] x_start, y_start, x_end, y_end;
    logic             band, empty, go;

    // Clip the requested rectangle; pixel ops are a one-pixel rectangle.
    always_comb begin
        x_start = {1'b0, i_data.x_left};
        y_start = {1'b0, i_data.y_top};
        case (i_data.op)
            OP_HBAND: begin
                x_end = {1'b0, i_data.x_right};
                y_end = y_start + {1'b0, i_data.thickness} - EXT_W'(1);
            end
            OP_VBAND: begin
                x_end = x_start + {1'b0, i_data.thickness} - EXT_W'(1);
                y_end = {1'b0, i_data.y_bottom};
            end
            default: begin
                x_end = x_start;
                y_end = y_start;
            end
        endcase
        band  = (i_data.op == OP_HBAND) || (i_data.op == OP_VBAND);
        empty = band && ((i_data.thickness == '0) || (x_end < x_start) || (y_end < y_start));
        go    = !empty && (x_start < X_LIM) && (y_start < Y_LIM);
    end

    always_comb begin
        n_state    = r_state;
        n_x        = r_x;
        n_y        = r_y;
        n_x0       = r_x0;
        n_xe       = r_xe;
        n_ye       = r_ye;
        n_row_base = r_row_base;
        n_color    = r_color;
        n_rd       = r_rd;
        n_flag     = r_flag;
        o_ready     = 1'b0;
        o_start     = 1'b0;
        o_res_valid = 1'b0;
        o_pix.valid = 1'b0;
        o_pix.rd    = r_rd;
        o_pix.hi    = !r_x[0];
        o_pix.color = r_color;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_start = 1'b1;
                    n_x     = i_data.x_left;
                    n_y     = i_data.y_top;
                    n_x0    = i_data.x_left;
                    n_xe    = (x_end >= X_LIM) ? X_LAST : x_end[COORD_W-1:0];
                    n_ye    = (y_end >= Y_LIM) ? Y_LAST : y_end[COORD_W-1:0];
                    n_color = i_data.color;
                    n_rd    = (i_data.op == OP_READ);
                    n_flag  = !empty && ((x_end >= X_LIM) || (y_end >= Y_LIM));
                    n_state = go ? ST_PREP : ST_RESP;
                end
            end
            ST_PREP: begin
                n_row_base = ADDR_W'(r_y * ROW_STEP);
                n_state    = ST_WALK;
            end
            ST_WALK: begin
                o_pix.valid = 1'b1;
                if (r_x == r_xe) begin
                    n_x        = r_x0;
                    n_y        = r_y + COORD_W'(1);
                    n_row_base = r_row_base + ROW_STEP;
                    if (r_y == r_ye) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_x = r_x + COORD_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_x0       <= n_x0;
        r_xe       <= n_xe;
        r_ye       <= n_ye;
        r_row_base <= n_row_base;
        r_color    <= n_color;
        r_rd       <= n_rd;
        r_flag     <= n_flag;
    end

    assign o_raddr      = r_row_base + ADDR_W'(r_x[COORD_W-1:1]);
    assign o_res_status = r_flag;

endmodule

// ===== hw/rtl/pnff_rmw.sv =====
// Read-modify-write stage on the frame store byte, with write forwarding.
`timescale 1ns / 1ps

module pnff_rmw import pnff_pkg::*; #(
    parameter int ADDR_W = 17
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  t_pix_ctl            i_pix,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [BYTE_W-1:0]   i_rd_data,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [BYTE_W-1:0]   o_wdata,
    output logic [NIBBLE_W-1:0] o_read_color
);

    t_pix_ctl            r_pix;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_fw_valid;
    logic [ADDR_W-1:0]   r_fw_addr;
    logic [BYTE_W-1:0]   r_fw_data;
    logic [NIBBLE_W-1:0] r_rc, n_rc;
    logic [BYTE_W-1:0]   cur_byte;

    // A write issued in the same cycle as this byte's read is not in the RAM data.
    assign cur_byte = (r_fw_valid && (r_fw_addr == r_addr)) ? r_fw_data : i_rd_data;

    assign o_we    = r_pix.valid && !r_pix.rd;
    assign o_waddr = r_addr;
    assign o_wdata = r_pix.hi ? {r_pix.color, cur_byte[NIBBLE_W-1:0]}
                              : {cur_byte[BYTE_W-1:NIBBLE_W], r_pix.color};

    always_comb begin
        n_rc = r_rc;
        if (i_clear) begin
            n_rc = '0;
        end else if (r_pix.valid && r_pix.rd) begin
            n_rc = NIBBLE_W'(cur_byte >> (r_pix.hi ? NIBBLE_W : 0)) & NIBBLE_MASK;
        end
    end

    // Only the valid bits are reset; the data fields follow them unconditionally.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix.valid <= 1'b0;
            r_fw_valid  <= 1'b0;
        end else begin
            r_pix.valid <= i_pix.valid;
            r_fw_valid  <= o_we;
        end
        r_pix.rd    <= i_pix.rd;
        r_pix.hi    <= i_pix.hi;
        r_pix.color <= i_pix.color;
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= i_addr;
        r_fw_addr   <= o_waddr;
        r_fw_data   <= o_wdata;
        r_rc        <= n_rc;
    end

    assign o_read_color = r_rc;

endmodule

// ===== hw/rtl/packed_nibble_framebuffer_fill_unit.sv =====
// Top level of the packed 4-bit framebuffer pixel and band fill unit.
`timescale 1ns / 1ps

// Framebuffer of 4-bit pixels, two to a byte, even column in the high nibble.
// Input channel (i_valid/o_ready/i_data): one word per operation - write pixel,
// read pixel, horizontal band fill or vertical band fill.
// Output channel (o_valid/i_ready/o_data): exactly one word per operation,
// read_color (zero unless a pixel read) and status (1 when pixels fell off screen).
// Items are handled one at a time. From acceptance, an item with on-screen pixels
// passes through the row address, one walk step per pixel, the last write-back
// and the hand-over into the output register; with no pixel on screen it goes
// straight to the hand-over. The next word is accepted in the cycle after that.
// The pixel walk sets the rate: one pixel per cycle through a read-modify-write
// of the frame store byte, since the store has one read and one write port with
// a registered read.
// Back-to-back writes to the same byte are forwarded around the RAM.
// The result sits in an output register, so the next word is taken and worked
// on while the receiver stalls; a second result waits in its final state until
// the register frees up.
// Reset clears the control state only; the frame store is left undefined, and a
// pixel must be written before it is read.
module packed_nibble_framebuffer_fill_unit import pnff_pkg::*; #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 1) / 2;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [ADDR_W-1:0]   raddr;
    t_pix_ctl            pix;
    logic                start;
    logic                res_valid, res_ready, res_status;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [BYTE_W-1:0]   wdata, rdata;
    logic [NIBBLE_W-1:0] read_color;

    logic      r_o_valid, n_o_valid;
    t_out_word r_o_data, n_o_data;

    pnff_ctrl #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_raddr     (raddr),
        .o_pix       (pix),
        .o_start     (start),
        .o_res_valid (res_valid),
        .o_res_status(res_status),
        .i_res_ready (res_ready)
    );

    pnff_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES),
        .ADDR_W(ADDR_W)
    ) u_frame_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    pnff_rmw #(
        .ADDR_W(ADDR_W)
    ) u_rmw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (start),
        .i_pix       (pix),
        .i_addr      (raddr),
        .i_rd_data   (rdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_read_color(read_color)
    );

    // Output register: free when empty or being taken this cycle.
    assign res_ready = !r_o_valid || i_ready;

    always_comb begin
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        if (res_valid && res_ready) begin
            n_o_valid           = 1'b1;
            n_o_data.read_color = read_color;
            n_o_data.status     = res_status;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_data <= n_o_data;
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// ===== hw/rtl/pnff_checker.sv =====
// Port-level checker for the framebuffer fill unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pnff_checker import pnff_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_word  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_data
);

    // Result word holds until taken.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid, "result dropped")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(o_data), "result changed while stalled")
    // One operation at a time: busy straight after an accepted word.
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "accepted a second word while busy")
    // Reset empties the output register.
    `ASSERT_CLK_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind packed_nibble_framebuffer_fill_unit pnff_checker u_pnff_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .i_data (i_data),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
